// ===== src/bal_pkg.sv =====
package bal_pkg;

   // Tree and pool geometry
   localparam int MAX_LEVELS   = 8;
   localparam int HEADER_BYTES = 16;
   localparam int NODE_AW      = MAX_LEVELS;
   localparam int NODE_COUNT   = 1 << NODE_AW;
   localparam int UNIT_AW      = MAX_LEVELS - 1;
   localparam int UNIT_COUNT   = 1 << UNIT_AW;
   localparam int DEP_W        = $clog2(MAX_LEVELS + 1);

   // Field widths
   localparam int ADDR_W = 20;
   localparam int LEN_W  = 20;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;
   localparam int LVL_W  = 3;
   localparam int TAG_W  = 4;
   localparam int CFG_W  = 4;
   localparam int CIDX_W = 2;

   // Register indexes
   localparam logic [CIDX_W-1:0] CSR_BASE_LOG2 = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_LEVELS    = 2'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] BASE_RESET   = 4'd4;
   localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_MEM    = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   // Free map port: one write and one read per cycle
   typedef struct packed {
      logic               we;
      logic [NODE_AW-1:0] waddr;
      logic               wdata;
      logic [NODE_AW-1:0] raddr;
   } fm_cmd_type;

   // Allocation tag port
   typedef struct packed {
      logic               we;
      logic [UNIT_AW-1:0] waddr;
      logic [TAG_W-1:0]   wdata;
      logic [UNIT_AW-1:0] raddr;
   } tag_cmd_type;

endpackage

// ===== src/bal_if.sv =====
interface bal_req_if;
   logic                        valid;
   logic                        ready;
   logic [bal_pkg::MODE_W-1:0]  mode;
   logic [bal_pkg::LEN_W-1:0]   request_length;
   logic [bal_pkg::ADDR_W-1:0]  free_address;
   modport source (output valid, mode, request_length, free_address, input ready);
   modport sink   (input valid, mode, request_length, free_address, output ready);
endinterface

interface bal_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bal_pkg::ADDR_W-1:0]  block_address;
   logic [bal_pkg::STAT_W-1:0]  status;
   logic [bal_pkg::LVL_W-1:0]   block_level;
   modport source (output valid, block_address, status, block_level, input ready);
   modport sink   (input valid, block_address, status, block_level, output ready);
endinterface

interface bal_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bal_pkg::CIDX_W-1:0]  index;
   logic [bal_pkg::CFG_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bal_ram.sv =====
module bal_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bal_ctrl.sv =====
module bal_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cfg_wr,
   input  logic [bal_pkg::CFG_W-1:0]  eff_b,
   input  logic [bal_pkg::CFG_W-1:0]  eff_l,
   bal_req_if.sink                    req,
   bal_rsp_if.source                  rsp,
   output bal_pkg::fm_cmd_type        fm_cmd,
   input  logic                       fm_rdata,
   output bal_pkg::tag_cmd_type       tag_cmd,
   input  logic [bal_pkg::TAG_W-1:0]  tag_rdata
);

   localparam int NAW = bal_pkg::NODE_AW;
   localparam int UAW = bal_pkg::UNIT_AW;
   localparam int DW  = bal_pkg::DEP_W;
   localparam int AW  = bal_pkg::ADDR_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_TAG,
      S_F_CHK, S_F_BRD, S_F_BCHK, S_F_SET, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [NAW-1:0]          clr_ff, clr_in;
   logic                    pend_ff, pend_in;
   logic [DW-1:0]           k_ff, k_in, d_ff, d_in, dj_ff, dj_in;
   logic [NAW-1:0]          n_ff, n_in;
   logic [UAW-1:0]          unit_ff, unit_in;
   logic [AW-1:0]           res_addr_ff, res_addr_in;
   bal_pkg::status_type     res_stat_ff, res_stat_in;
   logic [DW-1:0]           res_lvl_ff, res_lvl_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]           rsp_addr_ff, rsp_addr_in;
   logic [bal_pkg::STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [bal_pkg::LVL_W-1:0]  rsp_lvl_ff, rsp_lvl_in;

   logic [DW-1:0]           lm1;
   logic [AW:0]             need;
   logic                    fit;
   logic [DW-1:0]           ksel;
   logic [AW-1:0]           off;
   logic                    free_bad;
   logic [4:0]              top_sh;
   logic [DW-1:0]           tag_k, fd;
   logic                    tag_bad;
   logic [NAW-1:0]          fn;
   logic [NAW-1:0]          rel;
   logic [4:0]              a_sh;
   logic                    last_node;
   logic                    out_free;

   assign lm1 = DW'(eff_l - 4'd1);

   // Size class for an allocate: smallest class whose block holds length plus header
   always_comb begin
      need = {1'b0, req.request_length} + (AW+1)'(bal_pkg::HEADER_BYTES);
      fit  = 1'b0;
      ksel = '0;
      for (int i = bal_pkg::MAX_LEVELS - 1; i >= 0; i--) begin
         if (i < int'(eff_l) && ((21'd1 << (int'(eff_b) + i)) >= need)) begin
            fit  = 1'b1;
            ksel = DW'(i);
         end
      end
   end

   // Free address checks that need no memory read
   always_comb begin
      off      = req.free_address - AW'(bal_pkg::HEADER_BYTES);
      top_sh   = {1'b0, eff_b} + 5'(lm1);
      free_bad = (req.free_address < AW'(bal_pkg::HEADER_BYTES))
               || ((off & ~({AW{1'b1}} << eff_b)) != '0)
               || ((off >> top_sh) != '0);
   end

   // Tag checks and leaf node of the block being freed
   always_comb begin
      tag_k   = DW'(tag_rdata - 4'd1);
      tag_bad = (tag_rdata == '0) || (tag_rdata > eff_l)
              || ((unit_ff & ~({UAW{1'b1}} << tag_k)) != '0);
      fd      = lm1 - tag_k;
      fn      = (NAW'(1) << fd) | NAW'(unit_ff >> tag_k);
   end

   assign rel       = n_ff - (NAW'(1) << d_ff);
   assign a_sh      = {1'b0, eff_b} + 5'(k_ff);
   assign last_node = (n_ff == NAW'((2 << dj_ff) - 1));
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.block_address = rsp_addr_ff;
   assign rsp.status        = rsp_stat_ff;
   assign rsp.block_level   = rsp_lvl_ff;

   // Next state and memory commands
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      dj_in        = dj_ff;
      n_in         = n_ff;
      unit_in      = unit_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      res_lvl_in   = res_lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      fm_cmd       = '0;
      tag_cmd      = '0;

      case (state_ff)
         // sweep both stores back to one free top block
         S_CLEAR: begin
            fm_cmd.we     = 1'b1;
            fm_cmd.waddr  = clr_ff;
            fm_cmd.wdata  = (clr_ff == NAW'(1));
            tag_cmd.we    = 1'b1;
            tag_cmd.waddr = clr_ff[UAW-1:0];
            tag_cmd.wdata = '0;
            clr_in        = clr_ff + NAW'(1);
            if (clr_ff == {NAW{1'b1}}) begin
               state_in = pend_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               res_addr_in = '0;
               res_stat_in = bal_pkg::ST_OK;
               res_lvl_in  = '0;
               case (bal_pkg::mode_type'(req.mode))
                  bal_pkg::MODE_INIT: begin
                     clr_in   = '0;
                     pend_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
                  bal_pkg::MODE_ALLOC: begin
                     if (!fit) begin
                        res_stat_in = bal_pkg::ST_TOO_LARGE;
                        state_in    = S_DONE;
                     end else begin
                        k_in     = ksel;
                        d_in     = lm1 - ksel;
                        dj_in    = lm1 - ksel;
                        n_in     = NAW'(1) << (lm1 - ksel);
                        state_in = S_A_RD;
                     end
                  end
                  bal_pkg::MODE_FREE: begin
                     unit_in       = UAW'(off >> eff_b);
                     tag_cmd.raddr = UAW'(off >> eff_b);
                     if (free_bad) begin
                        res_stat_in = bal_pkg::ST_NOT_ALLOC;
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_F_CHK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // scan one depth at a time, lowest address first
         S_A_RD: begin
            fm_cmd.raddr = n_ff;
            state_in     = S_A_CHK;
         end
         S_A_CHK: begin
            if (fm_rdata) begin
               fm_cmd.we    = 1'b1;
               fm_cmd.waddr = n_ff;
               fm_cmd.wdata = 1'b0;
               state_in     = (dj_ff == d_ff) ? S_A_TAG : S_A_SPLIT;
            end else if (!last_node) begin
               n_in     = n_ff + NAW'(1);
               state_in = S_A_RD;
            end else if (dj_ff == '0) begin
               res_stat_in = bal_pkg::ST_NO_MEM;
               res_lvl_in  = k_ff;
               state_in    = S_DONE;
            end else begin
               dj_in    = dj_ff - DW'(1);
               n_in     = NAW'(1) << (dj_ff - DW'(1));
               state_in = S_A_RD;
            end
         end
         // split down, upper half goes free
         S_A_SPLIT: begin
            fm_cmd.we    = 1'b1;
            fm_cmd.waddr = {n_ff[NAW-2:0], 1'b1};
            fm_cmd.wdata = 1'b1;
            n_in         = {n_ff[NAW-2:0], 1'b0};
            dj_in        = dj_ff + DW'(1);
            if (dj_ff + DW'(1) == d_ff) begin
               state_in = S_A_TAG;
            end
         end
         S_A_TAG: begin
            tag_cmd.we    = 1'b1;
            tag_cmd.waddr = UAW'(rel << k_ff);
            tag_cmd.wdata = bal_pkg::TAG_W'(k_ff) + bal_pkg::TAG_W'(1);
            res_addr_in   = AW'(AW'(rel) << a_sh) + AW'(bal_pkg::HEADER_BYTES);
            res_lvl_in    = k_ff;
            state_in      = S_DONE;
         end
         // tag data is back for the unit being freed
         S_F_CHK: begin
            if (tag_bad) begin
               res_stat_in = bal_pkg::ST_NOT_ALLOC;
               state_in    = S_DONE;
            end else begin
               tag_cmd.we    = 1'b1;
               tag_cmd.waddr = unit_ff;
               tag_cmd.wdata = '0;
               res_lvl_in    = tag_k;
               n_in          = fn;
               d_in          = fd;
               state_in      = (fd == '0) ? S_F_SET : S_F_BRD;
            end
         end
         S_F_BRD: begin
            fm_cmd.raddr = n_ff ^ NAW'(1);
            state_in     = S_F_BCHK;
         end
         // buddy free: take it out and climb; else mark this node free
         S_F_BCHK: begin
            if (fm_rdata) begin
               fm_cmd.we    = 1'b1;
               fm_cmd.waddr = n_ff ^ NAW'(1);
               fm_cmd.wdata = 1'b0;
               n_in         = n_ff >> 1;
               d_in         = d_ff - DW'(1);
               state_in     = (d_ff == DW'(1)) ? S_F_SET : S_F_BRD;
            end else begin
               fm_cmd.we    = 1'b1;
               fm_cmd.waddr = n_ff;
               fm_cmd.wdata = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_F_SET: begin
            fm_cmd.we    = 1'b1;
            fm_cmd.waddr = n_ff;
            fm_cmd.wdata = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_lvl_in   = bal_pkg::LVL_W'(res_lvl_ff);
               pend_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write restarts the pool
      if (cfg_wr) begin
         state_in = S_CLEAR;
         clr_in   = '0;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      d_ff        <= d_in;
      dj_ff       <= dj_in;
      n_ff        <= n_in;
      unit_ff     <= unit_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      res_lvl_ff  <= res_lvl_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_lvl_ff  <= rsp_lvl_in;
   end

endmodule

// ===== src/buddy_allocator_top.sv =====
// Channel  Dir  Payload                                   Accepted when
// req      in   mode, request_length, free_address        req_bus valid & ready
// rsp      out  block_address, status, block_level        rsp_bus valid & ready
// csr      in   index (0 base_log2, 1 levels_in_use), data csr_bus valid & ready
//
// One item at a time; the free map and tag store are single-port-read RAMs.
// Allocate: reads and checks each tree node scanned (up to 2^L - 1 nodes), then splits the block found down.
// Free: checks the tag, then reads and checks each buddy while climbing. Reinit: clearing pass.
// Reset and each register write run the clearing pass over all 256 nodes; req_bus.ready is low.
// The result register lets the next item be accepted while rsp_bus is stalled.
module buddy_allocator_top (
   input logic        clock,
   input logic        reset,
   bal_req_if.sink    req_bus,
   bal_rsp_if.source  rsp_bus,
   bal_csr_if.sink    csr_bus
);

   logic [bal_pkg::CFG_W-1:0]  base_ff, base_in, levels_ff, levels_in;
   logic [bal_pkg::CFG_W-1:0]  eff_b, eff_l;
   logic [bal_pkg::CFG_W:0]    lim;
   logic                       csr_wr;
   bal_pkg::fm_cmd_type        fm_cmd;
   bal_pkg::tag_cmd_type       tag_cmd;
   logic                       fm_rdata;
   logic [bal_pkg::TAG_W-1:0]  tag_rdata;

   assign csr_bus.ready = 1'b1;
   assign csr_wr = csr_bus.valid
                && (csr_bus.index == bal_pkg::CSR_BASE_LOG2
                    || csr_bus.index == bal_pkg::CSR_LEVELS);

   // Configuration registers
   always_comb begin
      base_in   = base_ff;
      levels_in = levels_ff;
      if (csr_bus.valid && csr_bus.index == bal_pkg::CSR_BASE_LOG2) begin
         base_in = csr_bus.data;
      end
      if (csr_bus.valid && csr_bus.index == bal_pkg::CSR_LEVELS) begin
         levels_in = csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= bal_pkg::BASE_RESET;
         levels_ff <= bal_pkg::LEVELS_RESET;
      end else begin
         base_ff   <= base_in;
         levels_ff <= levels_in;
      end
   end

   // Saturate registers so every address stays within 20 bits
   always_comb begin
      eff_b = base_ff;
      if (eff_b < 4'd2)  eff_b = 4'd2;
      if (eff_b > 4'd12) eff_b = 4'd12;
      lim   = 5'd20 - {1'b0, eff_b};
      eff_l = levels_ff;
      if (eff_l < 4'd1) eff_l = 4'd1;
      if (eff_l > bal_pkg::CFG_W'(bal_pkg::MAX_LEVELS)) begin
         eff_l = bal_pkg::CFG_W'(bal_pkg::MAX_LEVELS);
      end
      if ({1'b0, eff_l} > lim) eff_l = lim[bal_pkg::CFG_W-1:0];
   end

   bal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (csr_wr),
      .eff_b     (eff_b),
      .eff_l     (eff_l),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .fm_cmd    (fm_cmd),
      .fm_rdata  (fm_rdata),
      .tag_cmd   (tag_cmd),
      .tag_rdata (tag_rdata)
   );

   bal_ram #(.WIDTH(1), .DEPTH(bal_pkg::NODE_COUNT)) u_free_map (
      .clock (clock),
      .we    (fm_cmd.we),
      .waddr (fm_cmd.waddr),
      .wdata (fm_cmd.wdata),
      .raddr (fm_cmd.raddr),
      .rdata (fm_rdata)
   );

   bal_ram #(.WIDTH(bal_pkg::TAG_W), .DEPTH(bal_pkg::UNIT_COUNT)) u_alloc_tag (
      .clock (clock),
      .we    (tag_cmd.we),
      .waddr (tag_cmd.waddr),
      .wdata (tag_cmd.wdata),
      .raddr (tag_cmd.raddr),
      .rdata (tag_rdata)
   );

   // Reset and register writes both start the clearing pass
   a_reset_clears: assert property (@(posedge clock) reset |=> !req_bus.ready)
      else $error("item accepted right after reset");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_bus.ready)
      else $error("item accepted right after register write");

   // Only a successful allocate carries an address
   a_addr_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.block_address != '0 |-> rsp_bus.status == bal_pkg::ST_OK)
      else $error("address returned with error status");

   // Too large and not-allocated answers carry level 0
   a_err_level: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == bal_pkg::ST_TOO_LARGE
                        || rsp_bus.status == bal_pkg::ST_NOT_ALLOC)
      |-> rsp_bus.block_level == '0)
      else $error("nonzero level on rejected item");

endmodule

// ===== verif/buddy_allocator_top_tb.sv =====
module buddy_allocator_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [bal_pkg::ADDR_W-1:0] addr;
      bal_pkg::status_type        status;
      logic [bal_pkg::LVL_W-1:0]  level;
   } answer_type;

   typedef struct {
      bal_pkg::mode_type          mode;
      logic [bal_pkg::LEN_W-1:0]  len;
      logic [bal_pkg::ADDR_W-1:0] addr;
      bit                         typed;
      answer_type                 ans;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bal_req_if req_bus ();
   bal_rsp_if rsp_bus ();
   bal_csr_if csr_bus ();

   buddy_allocator_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // Shadow of the pool
   bit          pool_free [bal_pkg::NODE_COUNT];
   logic [3:0]  unit_tag  [bal_pkg::UNIT_COUNT];
   logic [3:0]  cfg_base;
   logic [3:0]  cfg_levels;
   logic [bal_pkg::ADDR_W-1:0] live_addrs [$];

   answer_type pending_answers [$];
   int      error_count;
   int      items_sent;
   int      answers_seen;
   int      alloc_ok, free_ok, rejects, cfg_writes;
   bit      quiet_stretch;

   function automatic int eff_base();
      int b;
      b = cfg_base;
      if (b < 2) b = 2;
      if (b > 12) b = 12;
      return b;
   endfunction

   function automatic int eff_levels();
      int l;
      l = cfg_levels;
      if (l < 1) l = 1;
      if (l > bal_pkg::MAX_LEVELS) l = bal_pkg::MAX_LEVELS;
      if (l > 20 - eff_base()) l = 20 - eff_base();
      return l;
   endfunction

   function automatic void clear_pool();
      foreach (pool_free[i]) pool_free[i] = 0;
      foreach (unit_tag[i]) unit_tag[i] = '0;
      pool_free[1] = 1;
      live_addrs.delete();
   endfunction

   // Apply one item to the shadow pool and return what the block must answer
   function automatic answer_type run_item(bal_pkg::mode_type m,
                                           logic [bal_pkg::LEN_W-1:0] len,
                                           logic [bal_pkg::ADDR_W-1:0] faddr);
      answer_type a;
      int b, l, k, d, dj, n, off, unit, tag;
      longint need;
      a.addr = '0; a.status = bal_pkg::ST_OK; a.level = '0;
      b = eff_base();
      l = eff_levels();
      if (m == bal_pkg::MODE_INIT) begin
         clear_pool();
      end else if (m == bal_pkg::MODE_ALLOC) begin
         need = longint'(len) + bal_pkg::HEADER_BYTES;
         k = 0;
         while (k < l && (longint'(1) << (b + k)) < need) k++;
         if (k >= l) begin
            a.status = bal_pkg::ST_TOO_LARGE;
            return a;
         end
         d = l - 1 - k;
         n = 0;
         dj = d + 1;
         while (dj > 0) begin
            dj--;
            n = 0;
            for (int j = 1 << dj; j < (2 << dj); j++)
               if (pool_free[j & (bal_pkg::NODE_COUNT - 1)]) begin
                  n = j;
                  break;
               end
            if (n != 0) break;
         end
         a.level = k[bal_pkg::LVL_W-1:0];
         if (n == 0) begin
            a.status = bal_pkg::ST_NO_MEM;
            return a;
         end
         pool_free[n] = 0;
         while (dj < d) begin
            pool_free[2 * n + 1] = 1;
            n = 2 * n;
            dj++;
         end
         off = (n - (1 << d)) << (b + k);
         unit_tag[(off >> b) & (bal_pkg::UNIT_COUNT - 1)] = 4'(k + 1);
         a.addr = bal_pkg::ADDR_W'(off + bal_pkg::HEADER_BYTES);
         live_addrs.push_back(a.addr);
      end else if (m == bal_pkg::MODE_FREE) begin
         a.status = bal_pkg::ST_NOT_ALLOC;
         if (faddr < bal_pkg::HEADER_BYTES) return a;
         off = int'(faddr) - bal_pkg::HEADER_BYTES;
         if ((off & ((1 << b) - 1)) != 0 || off >= (1 << (b + l - 1))) return a;
         unit = off >> b;
         tag = unit_tag[unit & (bal_pkg::UNIT_COUNT - 1)];
         if (tag == 0 || tag > l) return a;
         k = tag - 1;
         if ((unit & ((1 << k) - 1)) != 0) return a;
         unit_tag[unit & (bal_pkg::UNIT_COUNT - 1)] = '0;
         d = l - 1 - k;
         n = (1 << d) + (unit >> k);
         pool_free[n] = 1;
         while (d > 0 && pool_free[n ^ 1]) begin
            pool_free[n] = 0;
            pool_free[n ^ 1] = 0;
            n = n >> 1;
            d--;
            pool_free[n] = 1;
         end
         a.status = bal_pkg::ST_OK;
         a.level = k[bal_pkg::LVL_W-1:0];
         foreach (live_addrs[i])
            if (live_addrs[i] == faddr) begin
               live_addrs.delete(i);
               break;
            end
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Offer one item; returns after it is accepted
   task automatic send_item(bal_pkg::mode_type m, logic [bal_pkg::LEN_W-1:0] len,
                            logic [bal_pkg::ADDR_W-1:0] faddr, bit typed,
                            answer_type typed_ans);
      answer_type a;
      if (!quiet_stretch && $urandom_range(99) < 6) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.mode = m;
      req_bus.request_length = len;
      req_bus.free_address = faddr;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      a = run_item(m, len, faddr);
      if (typed && (a.addr != typed_ans.addr || a.status != typed_ans.status
                    || a.level != typed_ans.level))
         a = typed_ans; // table value wins; the model row is then caught on the port
      pending_answers.push_back(a);
      items_sent++;
      if (m == bal_pkg::MODE_ALLOC && a.status == bal_pkg::ST_OK) alloc_ok++;
      if (m == bal_pkg::MODE_FREE && a.status == bal_pkg::ST_OK) free_ok++;
      if (a.status != bal_pkg::ST_OK) rejects++;
      @(negedge clock);
   endtask

   // Register write while the block is idle
   task automatic write_reg(logic [bal_pkg::CIDX_W-1:0] idx,
                            logic [bal_pkg::CFG_W-1:0] value);
      req_bus.valid = 1'b0;
      wait (pending_answers.size() == 0);
      repeat (20) @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == bal_pkg::CSR_BASE_LOG2) cfg_base = value;
      else cfg_levels = value;
      clear_pool();
      cfg_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Random item, mostly allocations and frees of live blocks
   task automatic random_item();
      int pick, span;
      logic [bal_pkg::LEN_W-1:0] len;
      logic [bal_pkg::ADDR_W-1:0] faddr;
      bal_pkg::mode_type m;
      answer_type none;
      none = '{addr: '0, status: bal_pkg::ST_OK, level: '0};
      pick = $urandom_range(99);
      span = 1 << (eff_base() + eff_levels() - 1);
      len = bal_pkg::LEN_W'($urandom_range(0, span >> $urandom_range(0, eff_levels())));
      faddr = bal_pkg::ADDR_W'($urandom);
      if (pick < 48) begin
         m = bal_pkg::MODE_ALLOC;
         if ($urandom_range(9) == 0) len = bal_pkg::LEN_W'($urandom);
      end else if (pick < 90) begin
         m = bal_pkg::MODE_FREE;
         if (live_addrs.size() > 0 && $urandom_range(9) < 8)
            faddr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
         else if ($urandom_range(1) == 1)
            faddr = bal_pkg::ADDR_W'($urandom_range(0, span + bal_pkg::HEADER_BYTES));
      end else if (pick < 95) begin
         m = bal_pkg::MODE_INIT;
      end else begin
         m = bal_pkg::MODE_NONE;
      end
      send_item(m, len, faddr, 1'b0, none);
   endtask

   // Result side: random stalls plus one long hold-off
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && items_sent >= 60) begin
            held = 1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = quiet_stretch || ($urandom_range(99) >= 6);
         end
      end
   end

   // Compare each result with the oldest pending answer
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $display("%0t result with nothing pending", $realtime);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.block_address !== want.addr)
               report_mismatch("block_address", rsp_bus.block_address, want.addr);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.block_level !== want.level)
               report_mismatch("block_level", rsp_bus.block_level, want.level);
         end
      end
   end

   // Watchdog
   initial begin
      #40ms;
      $display("timeout with %0d results pending", pending_answers.size());
      $display("buddy_allocator_top_tb: errors");
      $finish;
   end

   // Directed table, expected values read off for the reset geometry (16 B x 8)
   stim_row_type directed [] = '{
      '{bal_pkg::MODE_ALLOC, 20'd0,     20'd0,     1, '{20'd16,   bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'hFFFFF, 20'd0,     1, '{20'd0,    bal_pkg::ST_TOO_LARGE, 3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd0,     1, '{20'd0,    bal_pkg::ST_NOT_ALLOC, 3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd17,    1, '{20'd0,    bal_pkg::ST_NOT_ALLOC, 3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd16,    1, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd2032,  20'd0,     1, '{20'd16,   bal_pkg::ST_OK,        3'd7}},
      '{bal_pkg::MODE_ALLOC, 20'd0,     20'd0,     1, '{20'd0,    bal_pkg::ST_NO_MEM,    3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd2033,  20'd0,     1, '{20'd0,    bal_pkg::ST_TOO_LARGE, 3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd16,    1, '{20'd0,    bal_pkg::ST_OK,        3'd7}},
      '{bal_pkg::MODE_NONE,  20'hFFFFF, 20'hFFFFF, 1, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'hFFFFF, 1, '{20'd0,    bal_pkg::ST_NOT_ALLOC, 3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd200,   20'd0,     0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd32,    1, '{20'd0,    bal_pkg::ST_NOT_ALLOC, 3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd17,    20'd0,     0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd1,     20'd0,     0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd500,   20'd0,     0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd1000,  20'd0,     0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd16,    0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd1040,  0, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_INIT,  20'hAAAAA, 20'h55555, 1, '{20'd0,    bal_pkg::ST_OK,        3'd0}},
      '{bal_pkg::MODE_FREE,  20'd0,     20'd16,    1, '{20'd0,    bal_pkg::ST_NOT_ALLOC, 3'd0}},
      '{bal_pkg::MODE_ALLOC, 20'd1008,  20'd0,     1, '{20'd16,   bal_pkg::ST_OK,        3'd6}},
      '{bal_pkg::MODE_ALLOC, 20'd1008,  20'd0,     1, '{20'd1040, bal_pkg::ST_OK,        3'd6}}
   };

   // Register settings per phase, extremes included
   logic [bal_pkg::CFG_W-1:0] phase_base   [] = '{4'd2, 4'd0,  4'd15, 4'd12, 4'd3, 4'd7, 4'd4};
   logic [bal_pkg::CFG_W-1:0] phase_levels [] = '{4'd8, 4'd15, 4'd1,  4'd8,  4'd0, 4'd3, 4'd5};

   initial begin
      error_count = 0;
      items_sent = 0;
      answers_seen = 0;
      alloc_ok = 0; free_ok = 0; rejects = 0; cfg_writes = 0;
      quiet_stretch = 0;
      req_bus.valid = 1'b0;
      req_bus.mode = bal_pkg::MODE_NONE;
      req_bus.request_length = '0;
      req_bus.free_address = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = bal_pkg::CSR_BASE_LOG2;
      csr_bus.data = '0;
      cfg_base = bal_pkg::BASE_RESET;
      cfg_levels = bal_pkg::LEVELS_RESET;
      clear_pool();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_item(directed[i].mode, directed[i].len, directed[i].addr,
                   directed[i].typed, directed[i].ans);

      // Random part at reset geometry, with a stretch free of idling
      for (int i = 0; i < 160; i++) begin
         quiet_stretch = (i >= 60 && i < 130);
         random_item();
      end
      quiet_stretch = 0;

      // Further phases under other register settings
      foreach (phase_base[p]) begin
         write_reg(bal_pkg::CSR_BASE_LOG2, phase_base[p]);
         write_reg(bal_pkg::CSR_LEVELS, phase_levels[p]);
         for (int i = 0; i < 42; i++) random_item();
      end

      req_bus.valid = 1'b0;
      wait (pending_answers.size() == 0);
      repeat (600) @(negedge clock);

      $display("sent %0d items, %0d results; %0d allocations and %0d frees succeeded",
               items_sent, answers_seen, alloc_ok, free_ok);
      $display("%0d rejected requests, %0d register writes", rejects, cfg_writes);
      if (error_count == 0 && pending_answers.size() == 0)
         $display("buddy_allocator_top_tb: clean");
      else
         $display("buddy_allocator_top_tb: errors");
      $finish;
   end

endmodule
